[design/mss_pkg.sv]
// mss_pkg: widths, stage structs and per-step helper functions for the merge core
// shared by mss_front, mss_divide, mss_sqrt and merge_sample_statistics_core
// no dependencies
package mss_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int FRAC_BITS   = 16;

    localparam int CNT_W  = 32;
    localparam int SUM_W  = 64;
    localparam int MEAN_W = 48;
    localparam int VAR_W  = 64;
    localparam int SMP_W  = 32;

    localparam int N_W   = CNT_W + 1;
    localparam int M_W   = 2 * N_W;
    localparam int DIV_W = M_W;
    localparam int DIV_QW = 64;
    localparam int DIV_STEPS = DIV_QW;
    localparam int X_W = 160;

    localparam int SQ_IN_W   = VAR_W + FRAC_BITS + ((VAR_W + FRAC_BITS) % 2);
    localparam int SQ_STEPS  = SQ_IN_W / 2;
    localparam int SQ_ROOT_W = SQ_STEPS;
    localparam int SQ_REM_W  = SQ_ROOT_W + 2;

    localparam logic [SMP_W-1:0] SAMPLE_MASK = {SMP_W{1'b1}} >> (SMP_W - SAMPLE_BITS);

    typedef struct packed {
        logic              pass;
        logic [CNT_W-1:0]  count;
        logic [SUM_W-1:0]  sum;
        logic [MEAN_W-1:0] mean;
        logic [VAR_W-1:0]  var_q;
        logic [SMP_W-1:0]  min_s;
        logic [SMP_W-1:0]  max_s;
    } t_side;

    typedef struct packed {
        logic [DIV_W-1:0]  rem;
        logic [DIV_W-1:0]  dvs;
        logic [DIV_QW-1:0] low;
    } t_lane;

    typedef struct packed {
        t_side side;
        logic  ovf;
        t_lane mean_l;
        t_lane t1_l;
        t_lane t2_l;
    } t_div;

    typedef struct packed {
        t_side                side;
        logic [SQ_IN_W-1:0]   x;
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
    } t_sq;

    // one restoring step: dividend bits shift out of low, quotient bits shift in
    function automatic t_lane div_lane_step(t_lane l);
        logic [DIV_W:0] t;
        t_lane          r;
        logic           q;
        t = {l.rem, l.low[DIV_QW-1]};
        r = l;
        if (t >= {1'b0, l.dvs}) begin
            r.rem = DIV_W'(t - {1'b0, l.dvs});
            q = 1'b1;
        end else begin
            r.rem = t[DIV_W-1:0];
            q = 1'b0;
        end
        r.low = {l.low[DIV_QW-2:0], q};
        return r;
    endfunction

    // one root bit per step, two radicand bits consumed from the top of x
    function automatic t_sq sqrt_step(t_sq s);
        logic [SQ_REM_W+1:0] t;
        logic [SQ_REM_W+1:0] trial;
        t_sq                 r;
        t = {s.rem, s.x[SQ_IN_W-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        r = s;
        r.x = s.x << 2;
        if (t >= trial) begin
            r.rem  = SQ_REM_W'(t - trial);
            r.root = {s.root[SQ_ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = t[SQ_REM_W-1:0];
            r.root = {s.root[SQ_ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

[design/mss_front.sv]
// mss_front: seven register stages of sums, partial products and divider setup
// uses mss_pkg
module mss_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [mss_pkg::CNT_W-1:0]    i_count_a,
    input  logic [mss_pkg::SUM_W-1:0]    i_sum_a,
    input  logic [mss_pkg::MEAN_W-1:0]   i_mean_a,
    input  logic [mss_pkg::VAR_W-1:0]    i_variance_a,
    input  logic [mss_pkg::SMP_W-1:0]    i_min_a,
    input  logic [mss_pkg::SMP_W-1:0]    i_max_a,
    input  logic [mss_pkg::CNT_W-1:0]    i_count_b,
    input  logic [mss_pkg::SUM_W-1:0]    i_sum_b,
    input  logic [mss_pkg::MEAN_W-1:0]   i_mean_b,
    input  logic [mss_pkg::VAR_W-1:0]    i_variance_b,
    input  logic [mss_pkg::SMP_W-1:0]    i_min_b,
    input  logic [mss_pkg::SMP_W-1:0]    i_max_b,
    output logic                         o_valid,
    output mss_pkg::t_div                o_data
);

    logic [6:0] r_v;

    mss_pkg::t_side r1_side, r2_side, r3_side, r4_side, r5_side, r6_side;
    logic [mss_pkg::N_W-1:0]  r1_n, r1_nm1, r2_n, r2_nm1, r3_n, r3_nm1;
    logic [mss_pkg::N_W-1:0]  r4_n, r4_nm1, r5_n, r5_nm1, r6_n, r6_nm1;
    logic [31:0] r1_na, r1_nb, r1_nm1a, r1_nm1b;
    logic [47:0] r1_ma, r1_mb, r1_d;
    logic [63:0] r1_va, r1_vb;

    logic [55:0] r2_pal, r2_pah, r2_pbl, r2_pbh;
    logic [63:0] r2_tal, r2_tah, r2_tbl, r2_tbh, r2_nn;
    logic [47:0] r2_dll, r2_dlh, r2_dhh;
    logic [mss_pkg::M_W-1:0] r2_m, r3_m, r4_m, r5_m, r6_m;

    logic [79:0] r3_pa, r3_pb;
    logic [95:0] r3_ta, r3_tb, r3_dsq;
    logic [63:0] r3_nn;

    logic [80:0] r4_p, r5_p, r6_p;
    logic [96:0] r4_t, r5_t, r6_t;
    logic [63:0] r4_pp [3][2];

    logic [127:0] r5_row0, r5_row1;
    logic [mss_pkg::X_W-1:0] r6_x;

    mss_pkg::t_div r7;

    logic [mss_pkg::SMP_W-1:0] w_mina, w_minb, w_maxa, w_maxb;
    logic [mss_pkg::CNT_W:0]   w_nsum;
    logic [mss_pkg::SUM_W:0]   w_ssum;
    logic                      w_pass, w_selb;
    logic [mss_pkg::X_W-1:0]   w_xfull;

    always_comb begin
        w_mina = i_min_a & mss_pkg::SAMPLE_MASK;
        w_minb = i_min_b & mss_pkg::SAMPLE_MASK;
        w_maxa = i_max_a & mss_pkg::SAMPLE_MASK;
        w_maxb = i_max_b & mss_pkg::SAMPLE_MASK;
        w_nsum = {1'b0, i_count_a} + {1'b0, i_count_b};
        w_ssum = {1'b0, i_sum_a} + {1'b0, i_sum_b};
        w_selb = (i_count_a == '0);
        w_pass = w_selb || (i_count_b == '0);
        w_xfull = mss_pkg::X_W'(r5_row0) + (mss_pkg::X_W'(r5_row1) << 32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: pass-through selection, count and sum, differences
            r1_side.pass <= w_pass;
            if (w_pass) begin
                r1_side.count <= w_selb ? i_count_b : i_count_a;
                r1_side.sum   <= w_selb ? i_sum_b : i_sum_a;
                r1_side.mean  <= w_selb ? i_mean_b : i_mean_a;
                r1_side.var_q <= w_selb ? i_variance_b : i_variance_a;
                r1_side.min_s <= w_selb ? w_minb : w_mina;
                r1_side.max_s <= w_selb ? w_maxb : w_maxa;
            end else begin
                r1_side.count <= w_nsum[mss_pkg::CNT_W] ? '1 : w_nsum[mss_pkg::CNT_W-1:0];
                r1_side.sum   <= w_ssum[mss_pkg::SUM_W] ? '1 : w_ssum[mss_pkg::SUM_W-1:0];
                r1_side.mean  <= '0;
                r1_side.var_q <= '0;
                r1_side.min_s <= (w_mina < w_minb) ? w_mina : w_minb;
                r1_side.max_s <= (w_maxa > w_maxb) ? w_maxa : w_maxb;
            end
            r1_n    <= w_nsum;
            r1_nm1  <= w_nsum - mss_pkg::N_W'(1);
            r1_na   <= i_count_a;
            r1_nb   <= i_count_b;
            r1_nm1a <= i_count_a - 32'd1;
            r1_nm1b <= i_count_b - 32'd1;
            r1_ma   <= i_mean_a;
            r1_mb   <= i_mean_b;
            r1_d    <= (i_mean_a > i_mean_b) ? i_mean_a - i_mean_b : i_mean_b - i_mean_a;
            r1_va   <= i_variance_a;
            r1_vb   <= i_variance_b;

            // stage 2: narrow partial products
            r2_side <= r1_side;
            r2_n    <= r1_n;
            r2_nm1  <= r1_nm1;
            r2_pal  <= 56'(r1_na) * 56'(r1_ma[23:0]);
            r2_pah  <= 56'(r1_na) * 56'(r1_ma[47:24]);
            r2_pbl  <= 56'(r1_nb) * 56'(r1_mb[23:0]);
            r2_pbh  <= 56'(r1_nb) * 56'(r1_mb[47:24]);
            r2_tal  <= 64'(r1_nm1a) * 64'(r1_va[31:0]);
            r2_tah  <= 64'(r1_nm1a) * 64'(r1_va[63:32]);
            r2_tbl  <= 64'(r1_nm1b) * 64'(r1_vb[31:0]);
            r2_tbh  <= 64'(r1_nm1b) * 64'(r1_vb[63:32]);
            r2_dll  <= 48'(r1_d[23:0]) * 48'(r1_d[23:0]);
            r2_dlh  <= 48'(r1_d[23:0]) * 48'(r1_d[47:24]);
            r2_dhh  <= 48'(r1_d[47:24]) * 48'(r1_d[47:24]);
            r2_nn   <= 64'(r1_na) * 64'(r1_nb);
            r2_m    <= mss_pkg::M_W'(r1_n) * mss_pkg::M_W'(r1_nm1);

            // stage 3: assemble products
            r3_side <= r2_side;
            r3_n    <= r2_n;
            r3_nm1  <= r2_nm1;
            r3_m    <= r2_m;
            r3_pa   <= (80'(r2_pah) << 24) + 80'(r2_pal);
            r3_pb   <= (80'(r2_pbh) << 24) + 80'(r2_pbl);
            r3_ta   <= (96'(r2_tah) << 32) + 96'(r2_tal);
            r3_tb   <= (96'(r2_tbh) << 32) + 96'(r2_tbl);
            r3_dsq  <= (96'(r2_dhh) << 48) + (96'(r2_dlh) << 25) + 96'(r2_dll);
            r3_nn   <= r2_nn;

            // stage 4: dividends and squared-difference by count product pieces
            r4_side <= r3_side;
            r4_n    <= r3_n;
            r4_nm1  <= r3_nm1;
            r4_m    <= r3_m;
            r4_p    <= 81'(r3_pa) + 81'(r3_pb);
            r4_t    <= 97'(r3_ta) + 97'(r3_tb);
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 2; j++) begin
                    r4_pp[k][j] <= 64'(r3_dsq[32*k +: 32]) * 64'(r3_nn[32*j +: 32]);
                end
            end

            // stage 5: rows of the wide product
            r5_side <= r4_side;
            r5_n    <= r4_n;
            r5_nm1  <= r4_nm1;
            r5_m    <= r4_m;
            r5_p    <= r4_p;
            r5_t    <= r4_t;
            r5_row0 <= 128'(r4_pp[0][0]) + (128'(r4_pp[1][0]) << 32)
                       + (128'(r4_pp[2][0]) << 64);
            r5_row1 <= 128'(r4_pp[0][1]) + (128'(r4_pp[1][1]) << 32)
                       + (128'(r4_pp[2][1]) << 64);

            // stage 6: full product, fraction scaling folded in as a shift
            r6_side <= r5_side;
            r6_n    <= r5_n;
            r6_nm1  <= r5_nm1;
            r6_m    <= r5_m;
            r6_p    <= r5_p;
            r6_t    <= r5_t;
            r6_x    <= w_xfull >> mss_pkg::FRAC_BITS;

            // stage 7: divider lanes, upper dividend bits preload the remainder
            r7.side <= r6_side;
            r7.ovf  <= (r6_x[mss_pkg::X_W-1:64] >= 96'(r6_m));
            r7.mean_l.rem <= mss_pkg::DIV_W'(r6_p[80:64]);
            r7.mean_l.dvs <= mss_pkg::DIV_W'(r6_n);
            r7.mean_l.low <= r6_p[63:0];
            r7.t1_l.rem   <= mss_pkg::DIV_W'(r6_t[96:64]);
            r7.t1_l.dvs   <= mss_pkg::DIV_W'(r6_nm1);
            r7.t1_l.low   <= r6_t[63:0];
            r7.t2_l.rem   <= (r6_x[mss_pkg::X_W-1:64] >= 96'(r6_m)) ? '0
                             : r6_x[64 +: mss_pkg::DIV_W];
            r7.t2_l.dvs   <= r6_m;
            r7.t2_l.low   <= r6_x[63:0];
        end
    end

    assign o_valid = r_v[6];
    assign o_data  = r7;

endmodule

[design/mss_divide.sv]
// mss_divide: pipelined restoring divider, one quotient bit per stage on three lanes
// uses mss_pkg
module mss_divide (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  mss_pkg::t_div i_data,
    output logic          o_valid,
    output mss_pkg::t_div o_data
);

    logic [mss_pkg::DIV_STEPS-1:0] r_v;
    mss_pkg::t_div                 r_st [mss_pkg::DIV_STEPS];
    mss_pkg::t_div                 w_prev [mss_pkg::DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[mss_pkg::DIV_STEPS-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < mss_pkg::DIV_STEPS; k++) begin : g_step
        if (k == 0) begin : g_first
            assign w_prev[k] = i_data;
        end else begin : g_next
            assign w_prev[k] = r_st[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k].side   <= w_prev[k].side;
                r_st[k].ovf    <= w_prev[k].ovf;
                r_st[k].mean_l <= mss_pkg::div_lane_step(w_prev[k].mean_l);
                r_st[k].t1_l   <= mss_pkg::div_lane_step(w_prev[k].t1_l);
                r_st[k].t2_l   <= mss_pkg::div_lane_step(w_prev[k].t2_l);
            end
        end
    end

    assign o_valid = r_v[mss_pkg::DIV_STEPS-1];
    assign o_data  = r_st[mss_pkg::DIV_STEPS-1];

endmodule

[design/mss_sqrt.sv]
// mss_sqrt: variance combine and saturation, then one root bit per stage
// uses mss_pkg
module mss_sqrt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  mss_pkg::t_div i_data,
    output logic          o_valid,
    output mss_pkg::t_sq  o_data
);

    logic                         r_cv;
    mss_pkg::t_sq                 r_c;
    logic [mss_pkg::SQ_STEPS-1:0] r_v;
    mss_pkg::t_sq                 r_st [mss_pkg::SQ_STEPS];
    mss_pkg::t_sq                 w_prev [mss_pkg::SQ_STEPS];

    logic [mss_pkg::VAR_W:0]   w_vsum;
    logic [mss_pkg::VAR_W-1:0] w_var;
    mss_pkg::t_side            w_side;

    always_comb begin
        w_vsum = {1'b0, i_data.t1_l.low} + {1'b0, i_data.t2_l.low};
        if (i_data.side.pass) begin
            w_var = i_data.side.var_q;
        end else if (i_data.ovf || w_vsum[mss_pkg::VAR_W]) begin
            w_var = '1;
        end else begin
            w_var = w_vsum[mss_pkg::VAR_W-1:0];
        end
        w_side       = i_data.side;
        w_side.var_q = w_var;
        w_side.mean  = i_data.side.pass ? i_data.side.mean
                       : i_data.mean_l.low[mss_pkg::MEAN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
            r_v  <= '0;
        end else if (i_en) begin
            r_cv <= i_valid;
            r_v  <= {r_v[mss_pkg::SQ_STEPS-2:0], r_cv};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c.side <= w_side;
            r_c.x    <= mss_pkg::SQ_IN_W'(w_var) << mss_pkg::FRAC_BITS;
            r_c.rem  <= '0;
            r_c.root <= '0;
        end
    end

    for (genvar k = 0; k < mss_pkg::SQ_STEPS; k++) begin : g_step
        if (k == 0) begin : g_first
            assign w_prev[k] = r_c;
        end else begin : g_next
            assign w_prev[k] = r_st[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= mss_pkg::sqrt_step(w_prev[k]);
            end
        end
    end

    assign o_valid = r_v[mss_pkg::SQ_STEPS-1];
    assign o_data  = r_st[mss_pkg::SQ_STEPS-1];

endmodule

[design/merge_sample_statistics_core.sv]
// merge_sample_statistics_core: merges two sample-group summaries into one
// one word per cycle sustained while the output is not stalled
// depth set by the 64-stage divider and the 40-stage square root pipeline
// a stalled output word freezes the whole pipeline until it is taken
// synchronous active-low reset clears the valid bits only; uses mss_pkg and submodules
module merge_sample_statistics_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [mss_pkg::CNT_W-1:0]    i_count_a,
    input  logic [mss_pkg::SUM_W-1:0]    i_sum_a,
    input  logic [mss_pkg::MEAN_W-1:0]   i_mean_a,
    input  logic [mss_pkg::VAR_W-1:0]    i_variance_a,
    input  logic [mss_pkg::SMP_W-1:0]    i_min_a,
    input  logic [mss_pkg::SMP_W-1:0]    i_max_a,
    input  logic [mss_pkg::CNT_W-1:0]    i_count_b,
    input  logic [mss_pkg::SUM_W-1:0]    i_sum_b,
    input  logic [mss_pkg::MEAN_W-1:0]   i_mean_b,
    input  logic [mss_pkg::VAR_W-1:0]    i_variance_b,
    input  logic [mss_pkg::SMP_W-1:0]    i_min_b,
    input  logic [mss_pkg::SMP_W-1:0]    i_max_b,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [mss_pkg::CNT_W-1:0]    o_count_out,
    output logic [mss_pkg::SUM_W-1:0]    o_sum_out,
    output logic [mss_pkg::MEAN_W-1:0]   o_mean_out,
    output logic [mss_pkg::VAR_W-1:0]    o_variance_out,
    output logic [mss_pkg::MEAN_W-1:0]   o_std_dev_out,
    output logic [mss_pkg::SMP_W-1:0]    o_min_out,
    output logic [mss_pkg::SMP_W-1:0]    o_max_out
);

    logic          w_en;
    logic          w_front_v, w_div_v, w_sq_v;
    mss_pkg::t_div w_front, w_div;
    mss_pkg::t_sq  w_sq;

    // pipeline moves unless a finished word is held at the output
    assign w_en    = !(w_sq_v && i_stall);
    assign o_stall = w_sq_v && i_stall;

    mss_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (i_valid),
        .i_count_a    (i_count_a),
        .i_sum_a      (i_sum_a),
        .i_mean_a     (i_mean_a),
        .i_variance_a (i_variance_a),
        .i_min_a      (i_min_a),
        .i_max_a      (i_max_a),
        .i_count_b    (i_count_b),
        .i_sum_b      (i_sum_b),
        .i_mean_b     (i_mean_b),
        .i_variance_b (i_variance_b),
        .i_min_b      (i_min_b),
        .i_max_b      (i_max_b),
        .o_valid      (w_front_v),
        .o_data       (w_front)
    );

    mss_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_v),
        .i_data  (w_front),
        .o_valid (w_div_v),
        .o_data  (w_div)
    );

    mss_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_v),
        .i_data  (w_div),
        .o_valid (w_sq_v),
        .o_data  (w_sq)
    );

    assign o_valid        = w_sq_v;
    assign o_count_out    = w_sq.side.count;
    assign o_sum_out      = w_sq.side.sum;
    assign o_mean_out     = w_sq.side.mean;
    assign o_variance_out = w_sq.side.var_q;
    assign o_std_dev_out  = mss_pkg::MEAN_W'(w_sq.root);
    assign o_min_out      = w_sq.side.min_s;
    assign o_max_out      = w_sq.side.max_s;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking testbench for merge_sample_statistics_core
// drives random and directed summary pairs, predicts merged summaries; uses mss_pkg

module tb;

    localparam int FRAC = mss_pkg::FRAC_BITS;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES = 300;

    typedef struct packed {
        logic [31:0] count;
        logic [63:0] sum;
        logic [47:0] mean;
        logic [63:0] variance;
        logic [47:0] std_dev;
        logic [31:0] min_s;
        logic [31:0] max_s;
    } merged_t;

    typedef struct packed {
        logic [31:0] count;
        logic [63:0] sum;
        logic [47:0] mean;
        logic [63:0] variance;
        logic [31:0] min_s;
        logic [31:0] max_s;
    } summary_t;

    class merge_scoreboard;
        merged_t pending[$];
        int      mismatches;

        function logic [47:0] root_of(logic [63:0] v);
            logic [255:0] x;
            logic [255:0] sq;
            logic [63:0]  r;
            logic [63:0]  c;
            x = 256'(v) << FRAC;
            r = '0;
            for (int b = 63; b >= 0; b--) begin
                c = r | (64'd1 << b);
                sq = 256'(c) * 256'(c);
                if (sq <= x) r = c;
            end
            return r[47:0];
        endfunction

        function void note_input(summary_t a, summary_t b);
            merged_t      m;
            summary_t     s;
            logic [255:0] n;
            logic [255:0] num;
            logic [255:0] q1;
            logic [255:0] q2;
            logic [255:0] d;
            logic [255:0] tot;
            if (a.count == 0 || b.count == 0) begin
                s = (a.count == 0) ? b : a;
                m.count = s.count;
                m.sum = s.sum;
                m.mean = s.mean;
                m.variance = s.variance;
                m.min_s = s.min_s;
                m.max_s = s.max_s;
            end else begin
                n = 256'(a.count) + 256'(b.count);
                m.count = (n > 256'hFFFF_FFFF) ? 32'hFFFF_FFFF : n[31:0];
                m.sum = (65'(a.sum) + 65'(b.sum) > 65'h0_FFFF_FFFF_FFFF_FFFF)
                        ? 64'hFFFF_FFFF_FFFF_FFFF : a.sum + b.sum;
                num = 256'(a.count) * 256'(a.mean) + 256'(b.count) * 256'(b.mean);
                q1 = num / n;
                m.mean = (q1 >> 64) != 0 ? 48'hFFFF_FFFF_FFFF : q1[47:0];
                num = (256'(a.count) - 1) * 256'(a.variance)
                    + (256'(b.count) - 1) * 256'(b.variance);
                q1 = num / (n - 1);
                d = (a.mean > b.mean) ? 256'(a.mean - b.mean) : 256'(b.mean - a.mean);
                num = d * d * 256'(a.count) * 256'(b.count);
                q2 = num / ((n * (n - 1)) << FRAC);
                tot = q1 + q2;
                m.variance = (tot >> 64) != 0 ? '1 : tot[63:0];
                m.min_s = (a.min_s < b.min_s) ? a.min_s : b.min_s;
                m.max_s = (a.max_s > b.max_s) ? a.max_s : b.max_s;
            end
            m.std_dev = root_of(m.variance);
            pending.push_back(m);
        endfunction

        function void check_result(merged_t got);
            merged_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word, count %0d", got.count);
                return;
            end
            e = pending.pop_front();
            if (got != e) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch exp cnt %h sum %h mean %h var %h sd %h min %h max %h",
                             e.count, e.sum, e.mean, e.variance, e.std_dev, e.min_s, e.max_s);
                    $display("         got cnt %h sum %h mean %h var %h sd %h min %h max %h",
                             got.count, got.sum, got.mean, got.variance, got.std_dev,
                             got.min_s, got.max_s);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid;
    summary_t in_a = '{default: '0};
    summary_t in_b = '{default: '0};
    logic [31:0] o_count_out, o_min_out, o_max_out;
    logic [63:0] o_sum_out, o_variance_out;
    logic [47:0] o_mean_out, o_std_dev_out;

    merge_scoreboard board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;
    int quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    merge_sample_statistics_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_count_a(in_a.count), .i_sum_a(in_a.sum), .i_mean_a(in_a.mean),
        .i_variance_a(in_a.variance), .i_min_a(in_a.min_s), .i_max_a(in_a.max_s),
        .i_count_b(in_b.count), .i_sum_b(in_b.sum), .i_mean_b(in_b.mean),
        .i_variance_b(in_b.variance), .i_min_b(in_b.min_s), .i_max_b(in_b.max_s),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_count_out(o_count_out), .o_sum_out(o_sum_out), .o_mean_out(o_mean_out),
        .o_variance_out(o_variance_out), .o_std_dev_out(o_std_dev_out),
        .o_min_out(o_min_out), .o_max_out(o_max_out)
    );

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // result checking and watchdog
    always @(posedge i_clk) begin
        merged_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.count = o_count_out;
            got.sum = o_sum_out;
            got.mean = o_mean_out;
            got.variance = o_variance_out;
            got.std_dev = o_std_dev_out;
            got.min_s = o_min_out;
            got.max_s = o_max_out;
            board.check_result(got);
        end
        if (i_rst_n && ((o_valid && !i_stall) || (i_valid && !o_stall)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // random value biased toward extremes and small numbers
    function automatic logic [63:0] pick(int bits);
        logic [63:0] m;
        m = (bits == 64) ? '1 : ((64'd1 << bits) - 1);
        case ($urandom_range(7))
            0: return 64'd0;
            1: return m;
            2: return 64'($urandom_range(5));
            3: return rnd64() & m & 64'hFFFF;
            default: return rnd64() & m;
        endcase
    endfunction

    function automatic summary_t rand_summary();
        summary_t s;
        s.count = (pick(32) == 0 && $urandom_range(3) != 0) ? $urandom_range(1, 4)
                  : 32'(pick(32));
        s.sum = pick(64);
        s.mean = 48'(pick(48));
        s.variance = pick(64);
        s.min_s = 32'(pick(32));
        s.max_s = 32'(pick(32));
        return s;
    endfunction

    task automatic send_word(summary_t a, summary_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_a <= a;
        in_b <= b;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        board.note_input(a, b);
    endtask

    task automatic send_pair(logic [31:0] na, logic [63:0] va, logic [47:0] ma,
                             logic [31:0] nb, logic [63:0] vb, logic [47:0] mb);
        summary_t a;
        summary_t b;
        a = rand_summary();
        b = rand_summary();
        a.count = na; a.variance = va; a.mean = ma;
        b.count = nb; b.variance = vb; b.mean = mb;
        send_word(a, b);
    endtask

    initial begin
        int waited;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: passthrough, single-sample groups, extremes, saturation
        send_pair(0, 64'd100, 48'd5, 0, 64'd7 << 16, 48'd9);
        send_pair(0, '1, '1, 3, '1, '1);
        send_pair(5, 64'd1234, 48'd77, 0, 64'd2, 48'd3);
        send_pair(1, '1, 48'd0, 1, '1, '1);
        send_pair('1, '1, '1, '1, '1, 48'd0);
        send_pair('1, 64'd0, 48'd0, 1, 64'd0, '1);
        send_pair(2, 64'd65536, 48'd65536, 2, 64'd131072, 48'd196608);
        send_pair(1, 64'd0, 48'd10, 1, 64'd0, 48'd10);
        send_pair(32'h8000_0000, '1, 48'h8000_0000_0000, 32'h8000_0000, '1, 48'd1);
        begin
            summary_t a;
            summary_t b;
            a = '{count: 3, sum: '1, mean: '1, variance: 0, min_s: 0, max_s: '1};
            b = '{count: 4, sum: '1, mean: 0, variance: 0, min_s: '1, max_s: 0};
            send_word(a, b);
            a = '{count: 7, sum: 64'h8000_0000_0000_0000, mean: 48'hAAAA_AAAA_AAAA,
                  variance: 64'h5555_5555_5555_5555, min_s: 32'hAAAA_AAAA,
                  max_s: 32'h5555_5555};
            b = '{count: 9, sum: 64'h8000_0000_0000_0000, mean: 48'h5555_5555_5555,
                  variance: 64'hAAAA_AAAA_AAAA_AAAA, min_s: 32'h5555_5555,
                  max_s: 32'hAAAA_AAAA};
            send_word(a, b);
        end

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                3: begin send_idle_pct = 13; recv_stall_pct = 13; end
                default: begin
                    send_idle_pct = 0; recv_stall_pct = 0;
                    hold_off = 400;
                end
            endcase
            for (int k = 0; k < 220; k++) send_word(rand_summary(), rand_summary());
        end
        i_valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        waited = 0;
        while (board.pending.size() != 0 && waited < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[merge_sample_statistics_core.f]
design/mss_pkg.sv
design/mss_front.sv
design/mss_divide.sv
design/mss_sqrt.sv
design/merge_sample_statistics_core.sv
tb/sv/tb.sv
